### hdl/bcd_add_multiply_unit_top_defines.svh
// Assertion macros for the BCD add and multiply unit.
`ifndef BCD_ADD_MULTIPLY_UNIT_TOP_DEFINES_SVH
`define BCD_ADD_MULTIPLY_UNIT_TOP_DEFINES_SVH

`define BAMU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define BAMU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bamu_pkg.sv
`default_nettype none
package bamu_pkg;

  localparam int DIGITS = 16;
  localparam int W = 4 * DIGITS;
  localparam int CW = 2 * DIGITS;
  localparam int MW = 4 * CW;
  localparam int HALF = (DIGITS + 1) / 2;
  localparam int ACCW = $clog2(DIGITS * 81 + 1);
  localparam int NS = 7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic [W:0] SIX_W = {1'b0, {DIGITS{4'h6}}};
  localparam logic [MW:0] SIX_M = {1'b0, {CW{4'h6}}};

  function automatic logic [ACCW-1:0] div10(input logic [ACCW-1:0] v);
    logic [ACCW+15:0] m;
    m = (ACCW + 16)'(v) * (ACCW + 16)'(52429);
    return ACCW'(m >> 19);
  endfunction

  function automatic logic [3:0] mod10(input logic [ACCW-1:0] v);
    logic [ACCW-1:0] q;
    q = div10(v);
    return 4'(v - ACCW'((q << 3) + (q << 1)));
  endfunction

endpackage
`default_nettype wire

### hdl/bcd_add_multiply_unit_top.sv
`default_nettype none
// BCD add and multiply unit: takes opcode (tuser, 0 add, 1 multiply) and two
// packed 16-digit BCD operands, returns the truncated BCD sum or product with a
// status (0 ok, 1 bad digit, 2 overflow). It is a seven-stage pipeline that
// accepts one transaction per cycle while the output is not stalled; the depth
// is set by the partial-product column sums, the decimal carry splits and the
// final 128-bit carry-propagate add. Every stage holds its item under
// backpressure.
`include "bcd_add_multiply_unit_top_defines.svh"
module bcd_add_multiply_unit_top import bamu_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,  // operand_a[63:0], operand_b[127:64]
  input  wire logic [0:0]   s_tuser,  // opcode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [71:0]       m_tdata   // result[63:0], status[65:64], zero
);

  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;
  logic          op [0:NS-2];
  logic          bad [0:NS-2];

  logic [W-1:0] a1, b1;
  logic [W:0]   t2, a2e, b2e;
  logic [6:0]   prod2 [DIGITS][DIGITS];
  logic [ACCW-1:0] h0 [CW];
  logic [ACCW-1:0] h1 [CW];
  logic [W-1:0] ares [2:NS-2];
  logic         aovf [2:NS-2];
  logic [7:0]   col4 [CW];
  logic [3:0]   v5 [CW];
  logic [MW:0]  t6, d6e, c6e;
  logic [W-1:0] res7;
  logic [1:0]   st7;

  logic bad_in;
  logic [6:0] prod_c [DIGITS][DIGITS];
  logic [ACCW-1:0] h0_c [CW];
  logic [ACCW-1:0] h1_c [CW];
  logic [W-1:0] ares_c;
  logic         aovf_c;
  logic [7:0]   col_c [CW];
  logic [3:0]   v_c [CW];
  logic [MW-1:0] dv_c, cv_c;
  logic [W-1:0] mres_c;
  logic         mhigh_c;
  logic [W-1:0] res_c;
  logic [1:0]   st_c;

  always_comb begin
    rdy[NS-1] = !vld[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_comb begin
    bad_in = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (s_tdata[4*i +: 4] > 4'd9 || s_tdata[64 + 4*i +: 4] > 4'd9) begin
        bad_in = 1'b1;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < DIGITS; j++) begin
      for (int i = 0; i < DIGITS; i++) begin
        prod_c[i][j] = 7'(a1[4*i +: 4]) * 7'(b1[4*j +: 4]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < CW; k++) begin
      h0_c[k] = '0;
      h1_c[k] = '0;
    end
    for (int j = 0; j < DIGITS; j++) begin
      for (int i = 0; i < DIGITS; i++) begin
        if (j < HALF) begin
          h0_c[i+j] = h0_c[i+j] + ACCW'(prod2[i][j]);
        end else begin
          h1_c[i+j] = h1_c[i+j] + ACCW'(prod2[i][j]);
        end
      end
    end
  end

  always_comb begin
    logic c;
    aovf_c = 1'b0;
    for (int k = 0; k < DIGITS; k++) begin
      c = t2[4*k+4] ^ a2e[4*k+4] ^ b2e[4*k+4] ^ SIX_W[4*k+4];
      ares_c[4*k +: 4] = c ? t2[4*k +: 4] : 4'(t2[4*k +: 4] - 4'd6);
      if (k == DIGITS - 1) begin
        aovf_c = c;
      end
    end
  end

  always_comb begin
    logic [ACCW-1:0] acc;
    logic [ACCW-1:0] q [CW];
    logic [3:0]      d [CW];
    for (int k = 0; k < CW; k++) begin
      acc = h0[k] + h1[k];
      q[k] = div10(acc);
      d[k] = mod10(acc);
    end
    col_c[0] = 8'(d[0]);
    for (int k = 1; k < CW; k++) begin
      col_c[k] = 8'(d[k]) + 8'(q[k-1]);
    end
  end

  always_comb begin
    logic [ACCW-1:0] q1 [CW];
    logic [3:0]      d1 [CW];
    logic [4:0]      v2 [CW];
    logic [ACCW-1:0] q2 [CW];
    logic [3:0]      d2 [CW];
    for (int k = 0; k < CW; k++) begin
      q1[k] = div10(ACCW'(col4[k]));
      d1[k] = mod10(ACCW'(col4[k]));
    end
    v2[0] = 5'(d1[0]);
    for (int k = 1; k < CW; k++) begin
      v2[k] = 5'(d1[k]) + 5'(q1[k-1]);
    end
    for (int k = 0; k < CW; k++) begin
      q2[k] = div10(ACCW'(v2[k]));
      d2[k] = mod10(ACCW'(v2[k]));
    end
    v_c[0] = d2[0];
    for (int k = 1; k < CW; k++) begin
      v_c[k] = d2[k] + 4'(q2[k-1]);
    end
  end

  always_comb begin
    dv_c = '0;
    cv_c = '0;
    for (int k = 0; k < CW; k++) begin
      dv_c[4*k +: 4] = (v5[k] >= 4'd10) ? 4'(v5[k] - 4'd10) : v5[k];
      if (k < CW - 1) begin
        cv_c[4*(k+1)] = (v5[k] >= 4'd10);
      end
    end
  end

  always_comb begin
    logic c;
    logic [3:0] dg;
    mhigh_c = 1'b0;
    mres_c = '0;
    for (int k = 0; k < CW; k++) begin
      c = t6[4*k+4] ^ d6e[4*k+4] ^ c6e[4*k+4] ^ SIX_M[4*k+4];
      dg = c ? t6[4*k +: 4] : 4'(t6[4*k +: 4] - 4'd6);
      if (k < DIGITS) begin
        mres_c[4*k +: 4] = dg;
      end else if (dg != 4'd0) begin
        mhigh_c = 1'b1;
      end
      if (k == CW - 1 && c) begin
        mhigh_c = 1'b1;
      end
    end
    if (bad[5]) begin
      res_c = '0;
      st_c = ST_BAD;
    end else if (!op[5]) begin
      res_c = ares[5];
      st_c = aovf[5] ? ST_OVF : ST_OK;
    end else begin
      res_c = mres_c;
      st_c = mhigh_c ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a1 <= s_tdata[W-1:0];
      b1 <= s_tdata[64 +: W];
      op[0] <= s_tuser[0];
      bad[0] <= bad_in;
    end
    if (rdy[1]) begin
      a2e <= {1'b0, a1};
      b2e <= {1'b0, b1};
      t2 <= {1'b0, a1} + {1'b0, b1} + SIX_W;
      prod2 <= prod_c;
      op[1] <= op[0];
      bad[1] <= bad[0];
    end
    if (rdy[2]) begin
      h0 <= h0_c;
      h1 <= h1_c;
      ares[2] <= ares_c;
      aovf[2] <= aovf_c;
      op[2] <= op[1];
      bad[2] <= bad[1];
    end
    if (rdy[3]) begin
      col4 <= col_c;
      ares[3] <= ares[2];
      aovf[3] <= aovf[2];
      op[3] <= op[2];
      bad[3] <= bad[2];
    end
    if (rdy[4]) begin
      v5 <= v_c;
      ares[4] <= ares[3];
      aovf[4] <= aovf[3];
      op[4] <= op[3];
      bad[4] <= bad[3];
    end
    if (rdy[5]) begin
      d6e <= {1'b0, dv_c};
      c6e <= {1'b0, cv_c};
      t6 <= {1'b0, dv_c} + {1'b0, cv_c} + SIX_M;
      ares[5] <= ares[4];
      aovf[5] <= aovf[4];
      op[5] <= op[4];
      bad[5] <= bad[4];
    end
    if (rdy[6]) begin
      res7 <= res_c;
      st7 <= st_c;
    end
  end

  assign m_tvalid = vld[NS-1];
  assign m_tdata = {6'd0, st7, 64'(res7)};

  `BAMU_ASSERT_NOW(a_bad_zero, m_tvalid && m_tdata[65:64] == ST_BAD, m_tdata[63:0] == 64'd0, "bad digit result not zero")
  `BAMU_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[65:64] != 2'd3, "undefined status code")
  `BAMU_ASSERT_NEXT(a_stage_hold, vld[NS-2] && !rdy[NS-2], vld[NS-2], "stalled stage dropped its item")

endmodule
`default_nettype wire
